FILE: hdl/fixed_block_free_list_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fixed block free list allocator
// Shared property templates, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define FBFL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fbfl assertion failed");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define FBFL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fbfl assertion failed");

`endif

FILE: hdl/fbfl_pkg.sv
// ----------------------------------------------------------------------------
// fbfl_pkg
// Widths, codes, reset values and helpers shared by the allocator modules.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  localparam int IDX_W      = 10;   // block index
  localparam int CNT_W      = 11;   // counts up to 1024
  localparam int SIZE_W     = 13;   // block size register
  localparam int OFF_W      = 22;   // byte offset
  localparam int CFG_W      = 13;   // widest register
  localparam int CFG_IDX_W  = 1;

  localparam int STACK_SLOTS    = 1024;
  localparam int POOL_DEPTH_DEF = 1024;
  localparam int Q_DEPTH        = 2;

  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST  = 13'd32;
  localparam logic [CNT_W-1:0]  BLOCK_COUNT_RST = 11'd1024;
  localparam logic [SIZE_W-1:0] SIZE_MIN        = 13'd8;
  localparam logic [SIZE_W-1:0] SIZE_MAX        = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NULL_FREE = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  // One classified request travelling from front to back.
  typedef struct packed {
    logic             granted;
    logic [IDX_W-1:0] index;
    status_t          status;
  } entry_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s < SIZE_MIN) r = SIZE_MIN;
    if (s > SIZE_MAX) r = SIZE_MAX;
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n,
                                                  input int unsigned depth);
    logic [CNT_W-1:0] r;
    r = n;
    if (32'(n) > depth) r = CNT_W'(depth);
    return r;
  endfunction

endpackage

FILE: hdl/fbfl_ram.sv
// ----------------------------------------------------------------------------
// fbfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbfl_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/fbfl_front.sv
// ----------------------------------------------------------------------------
// fbfl_front
// Accept and classify requests, keep the counters and the freed-block stack.
// ----------------------------------------------------------------------------
module fbfl_front #(
  parameter int STACK_DEPTH = 1024,
  localparam int AW        = $clog2(STACK_DEPTH)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic                           in_opcode,
  input  logic                           in_pointer_valid,
  input  logic [fbfl_pkg::IDX_W-1:0]     in_block_index,
  output logic                           in_full,
  input  logic                           rebuild,
  input  logic [fbfl_pkg::CNT_W-1:0]     rebuild_count,
  input  logic [fbfl_pkg::CNT_W-1:0]     eff_count,
  output fbfl_pkg::entry_t               q_entry,
  output logic                           q_valid,
  input  logic                           q_ready
);

  localparam int IW = fbfl_pkg::IDX_W;
  localparam int CW = fbfl_pkg::CNT_W;

  logic [CW-1:0]     freed_r, freed_nxt;
  logic [CW-1:0]     untouched_r, untouched_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_from_stack_r, s1_from_stack_nxt;
  logic              s1_granted_r, s1_granted_nxt;
  logic [IW-1:0]     s1_idx_r, s1_idx_nxt;
  fbfl_pkg::status_t s1_status_r, s1_status_nxt;

  logic          accept;
  logic [CW-1:0] freed_dec;
  logic [CW-1:0] untouched_dec;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_rdata;

  assign in_full       = s1_valid_r && !q_ready;
  assign accept        = in_push && !in_full;
  assign freed_dec     = freed_r - CW'(1);
  assign untouched_dec = untouched_r - CW'(1);

  always_comb begin
    freed_nxt         = freed_r;
    untouched_nxt     = untouched_r;
    s1_valid_nxt      = s1_valid_r;
    s1_from_stack_nxt = s1_from_stack_r;
    s1_granted_nxt    = s1_granted_r;
    s1_idx_nxt        = s1_idx_r;
    s1_status_nxt     = s1_status_r;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    if (rebuild) begin
      freed_nxt     = '0;
      untouched_nxt = rebuild_count;
    end else if (accept) begin
      s1_valid_nxt      = 1'b1;
      s1_from_stack_nxt = 1'b0;
      s1_granted_nxt    = 1'b0;
      s1_idx_nxt        = '0;
      s1_status_nxt     = fbfl_pkg::ST_OK;
      if (in_opcode == fbfl_pkg::OP_ALLOC) begin
        priority if (freed_r != '0) begin
          // pop the most recently freed block; data arrives next cycle
          ram_re            = 1'b1;
          freed_nxt         = freed_dec;
          s1_from_stack_nxt = 1'b1;
          s1_granted_nxt    = 1'b1;
        end else if (untouched_r != '0) begin
          untouched_nxt  = untouched_dec;
          s1_granted_nxt = 1'b1;
          s1_idx_nxt     = untouched_dec[IW-1:0];
        end else begin
          s1_status_nxt = fbfl_pkg::ST_EXHAUSTED;
        end
      end else begin
        priority if (!in_pointer_valid) begin
          s1_status_nxt = fbfl_pkg::ST_NULL_FREE;
        end else if ({1'b0, in_block_index} >= eff_count || freed_r >= eff_count) begin
          s1_status_nxt = fbfl_pkg::ST_BAD_FREE;
        end else begin
          ram_we    = 1'b1;
          freed_nxt = freed_r + CW'(1);
        end
      end
    end else if (q_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freed_r     <= '0;
      untouched_r <= fbfl_pkg::clamp_count(fbfl_pkg::BLOCK_COUNT_RST, STACK_DEPTH);
      s1_valid_r  <= 1'b0;
    end else begin
      freed_r     <= freed_nxt;
      untouched_r <= untouched_nxt;
      s1_valid_r  <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_from_stack_r <= s1_from_stack_nxt;
    s1_granted_r    <= s1_granted_nxt;
    s1_idx_r        <= s1_idx_nxt;
    s1_status_r     <= s1_status_nxt;
  end

  fbfl_ram #(
    .WIDTH (AW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (freed_r[AW-1:0]),
    .wdata (in_block_index[AW-1:0]),
    .re    (ram_re),
    .raddr (freed_dec[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign q_valid         = s1_valid_r;
  assign q_entry.granted = s1_granted_r;
  assign q_entry.index   = s1_from_stack_r ? IW'(ram_rdata) : s1_idx_r;
  assign q_entry.status  = s1_status_r;

endmodule

FILE: hdl/fbfl_queue.sv
// ----------------------------------------------------------------------------
// fbfl_queue
// Short FIFO of classified requests between the front and back sections.
// ----------------------------------------------------------------------------
module fbfl_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  fbfl_pkg::entry_t in_entry,
  input  logic             in_valid,
  output logic             in_ready,
  output fbfl_pkg::entry_t out_entry,
  output logic             out_valid,
  input  logic             out_ready
);

  localparam int DEPTH = fbfl_pkg::Q_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  fbfl_pkg::entry_t slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    count_r, count_nxt;
  logic             push, pop;

  assign in_ready  = count_r != NW'(DEPTH);
  assign out_valid = count_r != '0;
  assign out_entry = slot_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + NW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_entry;
    end
  end

endmodule

FILE: hdl/fbfl_back.sv
// ----------------------------------------------------------------------------
// fbfl_back
// Form the byte offset and hold the result register for the consumer.
// ----------------------------------------------------------------------------
module fbfl_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fbfl_pkg::entry_t            q_entry,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  logic [fbfl_pkg::SIZE_W-1:0] eff_size,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_granted,
  output logic [fbfl_pkg::IDX_W-1:0]  out_given_index,
  output logic [fbfl_pkg::OFF_W-1:0]  out_byte_offset,
  output logic [1:0]                  out_status
);

  localparam int PW = fbfl_pkg::IDX_W + fbfl_pkg::SIZE_W;

  logic                         out_valid_r, out_valid_nxt;
  logic                         granted_r;
  logic [fbfl_pkg::IDX_W-1:0]   index_r;
  logic [fbfl_pkg::OFF_W-1:0]   offset_r;
  fbfl_pkg::status_t            status_r;
  logic [PW-1:0]                prod;
  logic                         load;

  assign prod    = PW'(q_entry.index) * PW'(eff_size);
  assign q_ready = !out_valid_r || out_pop;
  assign load    = q_valid && q_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      granted_r <= q_entry.granted;
      index_r   <= q_entry.index;
      offset_r  <= prod[fbfl_pkg::OFF_W-1:0];
      status_r  <= q_entry.status;
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_granted     = granted_r;
  assign out_given_index = index_r;
  assign out_byte_offset = offset_r;
  assign out_status      = status_r;

endmodule

FILE: hdl/fixed_block_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_unit
// Fixed-size block pool allocator with a last-in first-out freed-block list.
// Push one request per cycle: an allocate (in_opcode 0) or a free (in_opcode
// 1). An allocate takes the most recently freed block, else the highest block
// never handed out, else reports the pool exhausted; a free pushes the block
// back, ignores a null pointer and drops an out-of-pool or overflowing free.
// Every request yields exactly one result, in order, on the out_ side. The
// block sustains one transfer per cycle on each side while no side stalls;
// a request passes through classify and stack access, the queue and the
// offset multiply. The one-per-cycle rate is set by the freed-block
// stack, a RAM with one write and one registered read port touched once per
// request; its registered read is why classification is a stage of its own.
// Register 0 is block_size (clamped to 8..4096), register 1 is block_count
// (capped at the pool depth); writing block_count empties the freed list
// and makes all blocks fresh again. Write registers only when idle.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_unit #(
  parameter int POOL_DEPTH = fbfl_pkg::POOL_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request side
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_opcode,
  input  logic                           in_pointer_valid,
  input  logic [fbfl_pkg::IDX_W-1:0]     in_block_index,
  // result side
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic                           out_granted,
  output logic [fbfl_pkg::IDX_W-1:0]     out_given_index,
  output logic [fbfl_pkg::OFF_W-1:0]     out_byte_offset,
  output logic [1:0]                     out_status,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbfl_pkg::CFG_W-1:0]     cfg_wdata
);

  // The stack never holds more entries than the pool has blocks, and the
  // index field caps the pool at the slot count.
  localparam int STACK_DEPTH = (POOL_DEPTH < fbfl_pkg::STACK_SLOTS) ?
                               POOL_DEPTH : fbfl_pkg::STACK_SLOTS;

  logic [fbfl_pkg::SIZE_W-1:0] block_size_r, block_size_nxt;
  logic [fbfl_pkg::CNT_W-1:0]  block_count_r, block_count_nxt;
  logic                        rebuild;
  logic [fbfl_pkg::CNT_W-1:0]  rebuild_count;
  logic [fbfl_pkg::CNT_W-1:0]  eff_count;
  logic [fbfl_pkg::SIZE_W-1:0] eff_size;

  fbfl_pkg::entry_t f2q_entry, q2b_entry;
  logic             f2q_valid, f2q_ready;
  logic             q2b_valid, q2b_ready;

  // Register file: a block_count write also rebuilds the pool.
  assign rebuild       = cfg_we && (cfg_index == fbfl_pkg::REG_BLOCK_COUNT);
  assign rebuild_count = fbfl_pkg::clamp_count(cfg_wdata[fbfl_pkg::CNT_W-1:0], STACK_DEPTH);

  always_comb begin
    block_size_nxt  = block_size_r;
    block_count_nxt = block_count_r;
    if (cfg_we) begin
      unique case (cfg_index)
        fbfl_pkg::REG_BLOCK_SIZE:  block_size_nxt  = cfg_wdata[fbfl_pkg::SIZE_W-1:0];
        fbfl_pkg::REG_BLOCK_COUNT: block_count_nxt = cfg_wdata[fbfl_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r  <= fbfl_pkg::BLOCK_SIZE_RST;
      block_count_r <= fbfl_pkg::BLOCK_COUNT_RST;
    end else begin
      block_size_r  <= block_size_nxt;
      block_count_r <= block_count_nxt;
    end
  end

  // Clamp once here and hand the effective values down.
  assign eff_count = fbfl_pkg::clamp_count(block_count_r, STACK_DEPTH);
  assign eff_size  = fbfl_pkg::clamp_size(block_size_r);

  // Front: accept, classify, update counters and the freed stack.
  fbfl_front #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_opcode        (in_opcode),
    .in_pointer_valid (in_pointer_valid),
    .in_block_index   (in_block_index),
    .in_full          (in_full),
    .rebuild          (rebuild),
    .rebuild_count    (rebuild_count),
    .eff_count        (eff_count),
    .q_entry          (f2q_entry),
    .q_valid          (f2q_valid),
    .q_ready          (f2q_ready)
  );

  // Decouple front and back so each can stall on its own.
  fbfl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_entry  (f2q_entry),
    .in_valid  (f2q_valid),
    .in_ready  (f2q_ready),
    .out_entry (q2b_entry),
    .out_valid (q2b_valid),
    .out_ready (q2b_ready)
  );

  // Back: multiply out the byte offset and present the result.
  fbfl_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_entry         (q2b_entry),
    .q_valid         (q2b_valid),
    .q_ready         (q2b_ready),
    .eff_size        (eff_size),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_granted     (out_granted),
    .out_given_index (out_given_index),
    .out_byte_offset (out_byte_offset),
    .out_status      (out_status)
  );

endmodule

FILE: hdl/fbfl_checker.sv
// ----------------------------------------------------------------------------
// fbfl_checker
// Port-level checks on the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "fixed_block_free_list_allocator_unit_macros.svh"

module fbfl_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_full,
  input logic                           out_empty,
  input logic                           out_pop,
  input logic                           out_granted,
  input logic [fbfl_pkg::IDX_W-1:0]     out_given_index,
  input logic [fbfl_pkg::OFF_W-1:0]     out_byte_offset,
  input logic [1:0]                     out_status
);

  // Both sides come out of reset with nothing in flight.
  `FBFL_ASSERT_IMPL(a_idle_after_reset, clk, rst_n, !$past(rst_n), out_empty && !in_full)

  // Back-pressure only reaches the input once a result is waiting.
  `FBFL_ASSERT_IMPL(a_full_needs_result, clk, rst_n, in_full, !out_empty)

  // A grant always reports ok.
  `FBFL_ASSERT_IMPL(a_grant_ok, clk, rst_n, !out_empty && out_granted, out_status == fbfl_pkg::ST_OK)

  // No grant: index and offset read zero.
  `FBFL_ASSERT_IMPL(a_no_grant_zero, clk, rst_n, !out_empty && !out_granted, out_given_index == '0 && out_byte_offset == '0)

  // A stalled result holds.
  `FBFL_ASSERT_NEXT(a_hold_stalled, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_given_index) && $stable(out_status))

endmodule

bind fixed_block_free_list_allocator_unit fbfl_checker u_fbfl_checker (.*);

FILE: test/fixed_block_free_list_allocator_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_unit_test
// Self-checking bench for the block pool allocator. Requests go in through
// the push/full queue port, and each transfer is predicted at once by a
// local copy of the pool: the freed-block stack, the fresh-block counter and
// both registers. A checker pops the results and compares every field with
// the oldest prediction. Directed cases cover the register extremes and the
// pool corner cases. Random traffic then runs under several idling mixes and
// a long receiver hold-off.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_unit_test;

  localparam int IDX_W          = fbfl_pkg::IDX_W;
  localparam int CNT_W          = fbfl_pkg::CNT_W;
  localparam int SIZE_W         = fbfl_pkg::SIZE_W;
  localparam int OFF_W          = fbfl_pkg::OFF_W;
  localparam int CFG_W          = fbfl_pkg::CFG_W;
  localparam int CFG_IDX_W      = fbfl_pkg::CFG_IDX_W;
  localparam int STACK_SLOTS    = fbfl_pkg::STACK_SLOTS;
  localparam int POOL_DEPTH_DEF = fbfl_pkg::POOL_DEPTH_DEF;

  localparam int CLK_HALF     = 4;       // 8 ns period
  localparam int DRAIN_CYCLES = 8;       // pipeline is three deep, pad it
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int CYCLE_LIMIT  = 200000;  // watchdog

  // One predicted result for one request.
  typedef struct {
    logic              granted;
    logic [IDX_W-1:0]  index;
    logic [OFF_W-1:0]  offset;
    fbfl_pkg::status_t status;
  } alloc_result_t;

  // Clock and reset.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Request side.
  logic             in_push          = 1'b0;
  logic             in_full;
  logic             in_opcode        = fbfl_pkg::OP_ALLOC;
  logic             in_pointer_valid = 1'b0;
  logic [IDX_W-1:0] in_block_index   = '0;

  // Result side.
  logic             out_empty;
  logic             out_pop = 1'b0;
  logic             out_granted;
  logic [IDX_W-1:0] out_given_index;
  logic [OFF_W-1:0] out_byte_offset;
  logic [1:0]       out_status;

  // Register writes.
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = fbfl_pkg::REG_BLOCK_SIZE;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Local copy of the pool.
  logic [IDX_W-1:0]  freed_list [STACK_SLOTS];
  logic [CNT_W-1:0]  freed_depth;
  logic [CNT_W-1:0]  fresh_left;
  logic [SIZE_W-1:0] size_reg;
  logic [CNT_W-1:0]  count_reg;

  // Blocks handed out and not yet returned; steers the random frees.
  logic [IDX_W-1:0] held_blocks [$];

  alloc_result_t pending_results [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic recv_hold    = 1'b0;
  int fail_count     = 0;
  int cycle_count    = 0;

  event hold_start_ev;

  fixed_block_free_list_allocator_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_opcode        (in_opcode),
    .in_pointer_valid (in_pointer_valid),
    .in_block_index   (in_block_index),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_granted      (out_granted),
    .out_given_index  (out_given_index),
    .out_byte_offset  (out_byte_offset),
    .out_status       (out_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // Watchdog: count every edge and give up at the limit.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Pool model
  // --------------------------------------------------------------------------

  // Rebuild empties the freed list and makes every block fresh again.
  function automatic void rebuild_pool();
    freed_depth = '0;
    fresh_left  = (int'(count_reg) > POOL_DEPTH_DEF) ? CNT_W'(POOL_DEPTH_DEF) : count_reg;
    held_blocks.delete();
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] val);
    if (idx == fbfl_pkg::REG_BLOCK_SIZE) begin
      // Size change only affects later offsets; the pool stays as it is.
      size_reg = val[SIZE_W-1:0];
    end else if (idx == fbfl_pkg::REG_BLOCK_COUNT) begin
      count_reg = val[CNT_W-1:0];
      rebuild_pool();
    end
  endfunction

  // Work out the result of one accepted request and advance the pool copy.
  function automatic alloc_result_t predict_request(input logic op,
                                                    input logic ptr_ok,
                                                    input logic [IDX_W-1:0] idx);
    alloc_result_t res;
    logic [CNT_W-1:0]  limit;
    logic [SIZE_W-1:0] sz;
    res.granted = 1'b0;
    res.index   = '0;
    res.offset  = '0;
    res.status  = fbfl_pkg::ST_OK;
    limit = (int'(count_reg) > POOL_DEPTH_DEF) ? CNT_W'(POOL_DEPTH_DEF) : count_reg;
    sz = size_reg;
    if (sz < 13'd8) sz = 13'd8;
    if (sz > 13'd4096) sz = 13'd4096;
    if (op == fbfl_pkg::OP_ALLOC) begin
      // Reuse the most recent free first, then hand out fresh blocks top down.
      if (freed_depth != 0) begin
        freed_depth = freed_depth - CNT_W'(1);
        res.index   = freed_list[freed_depth[IDX_W-1:0]];
        res.granted = 1'b1;
      end else if (fresh_left != 0) begin
        fresh_left  = fresh_left - CNT_W'(1);
        res.index   = fresh_left[IDX_W-1:0];
        res.granted = 1'b1;
      end else begin
        res.status = fbfl_pkg::ST_EXHAUSTED;
      end
      if (res.granted) begin
        res.offset  = OFF_W'(32'(res.index) * 32'(sz));
        held_blocks = {held_blocks, res.index};
      end
    end else begin
      if (!ptr_ok) begin
        res.status = fbfl_pkg::ST_NULL_FREE;
      end else if (CNT_W'(idx) >= limit || freed_depth >= limit) begin
        // Outside the pool, or the freed list is already full.
        res.status = fbfl_pkg::ST_BAD_FREE;
      end else begin
        freed_list[freed_depth[IDX_W-1:0]] = idx;
        freed_depth = freed_depth + CNT_W'(1);
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one request and hold it until the block takes the transfer.
  task automatic send_request(input logic op, input logic ptr_ok,
                              input logic [IDX_W-1:0] idx);
    alloc_result_t want;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push          <= 1'b1;
    in_opcode        <= op;
    in_pointer_valid <= ptr_ok;
    in_block_index   <= idx;
    @(posedge clk);
    while (in_full) @(posedge clk);
    want = predict_request(op, ptr_ok, idx);
    pending_results = {pending_results, want};
  endtask

  // Drop push and wait for the next edge so no request is taken twice.
  task automatic stop_input();
    in_push <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register once the block has gone idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    stop_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg_write(idx, val);
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic check_result();
    alloc_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending, index", out_given_index, 0);
    end else begin
      want = pending_results.pop_front();
      if (out_granted !== want.granted)
        report_mismatch("granted", out_granted, want.granted);
      if (out_given_index !== want.index)
        report_mismatch("given_index", out_given_index, want.index);
      if (out_byte_offset !== want.offset)
        report_mismatch("byte_offset", out_byte_offset, want.offset);
      if (out_status !== want.status)
        report_mismatch("status", out_status, want.status);
    end
  endtask

  // Pop side: check each transfer, then pick the next pop level.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) check_result();
    out_pop <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off, counted here so the sender can keep offering.
  initial begin
    forever begin
      @(hold_start_ev);
      recv_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      recv_hold <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: size 32, full pool of 1024, empty freed list.
  task automatic test_reset_defaults();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(fbfl_pkg::OP_ALLOC, 1'b0, 10'd0);     // top block first
    send_request(fbfl_pkg::OP_ALLOC, 1'b1, 10'd1023);
    send_request(fbfl_pkg::OP_FREE,  1'b1, 10'd1023);
    send_request(fbfl_pkg::OP_ALLOC, 1'b0, 10'd512);   // last freed comes back
    send_request(fbfl_pkg::OP_FREE,  1'b0, 10'd1023);  // null pointers are ignored
    send_request(fbfl_pkg::OP_FREE,  1'b0, 10'd0);
    send_request(fbfl_pkg::OP_FREE,  1'b1, 10'd0);     // never handed out, accepted
    send_request(fbfl_pkg::OP_ALLOC, 1'b1, 10'd0);
  endtask

  // Register extremes, exhaustion, bad frees, overflow and double frees.
  task automatic test_pool_edges();
    write_reg(fbfl_pkg::REG_BLOCK_SIZE, 13'd8191);     // clamps to 4096
    write_reg(fbfl_pkg::REG_BLOCK_COUNT, 13'd2047);    // capped at the pool depth
    send_request(fbfl_pkg::OP_ALLOC, 1'b0, 10'd0);     // largest offset

    write_reg(fbfl_pkg::REG_BLOCK_COUNT, 13'd1);
    write_reg(fbfl_pkg::REG_BLOCK_SIZE, 13'd0);        // clamps to 8
    send_request(fbfl_pkg::OP_ALLOC, 1'b0, 10'd0);
    send_request(fbfl_pkg::OP_ALLOC, 1'b0, 10'd0);     // exhausted
    send_request(fbfl_pkg::OP_FREE,  1'b1, 10'd1);     // outside the pool
    send_request(fbfl_pkg::OP_FREE,  1'b1, 10'd0);
    send_request(fbfl_pkg::OP_FREE,  1'b1, 10'd0);     // freed list full
    send_request(fbfl_pkg::OP_ALLOC, 1'b0, 10'd0);
    send_request(fbfl_pkg::OP_ALLOC, 1'b1, 10'd1023);

    write_reg(fbfl_pkg::REG_BLOCK_SIZE, 13'd4096);
    write_reg(fbfl_pkg::REG_BLOCK_COUNT, 13'd0);       // empty pool
    send_request(fbfl_pkg::OP_ALLOC, 1'b0, 10'd0);
    send_request(fbfl_pkg::OP_FREE,  1'b1, 10'd0);

    write_reg(fbfl_pkg::REG_BLOCK_COUNT, 13'd2);
    write_reg(fbfl_pkg::REG_BLOCK_SIZE, 13'd7);
    send_request(fbfl_pkg::OP_ALLOC, 1'b0, 10'd0);
    send_request(fbfl_pkg::OP_FREE,  1'b1, 10'd1);
    send_request(fbfl_pkg::OP_FREE,  1'b1, 10'd1);     // double free is pushed again
    send_request(fbfl_pkg::OP_ALLOC, 1'b0, 10'd0);
    write_reg(fbfl_pkg::REG_BLOCK_SIZE, 13'd100);      // no rebuild on a size write
    send_request(fbfl_pkg::OP_ALLOC, 1'b0, 10'd0);     // same block handed out twice
    send_request(fbfl_pkg::OP_ALLOC, 1'b0, 10'd0);
  endtask

  // Random traffic: mostly allocate and return, plus nulls and stray frees.
  task automatic run_traffic(input int n_items, input logic [CNT_W-1:0] count_val,
                             input int send_pct, input int recv_pct);
    int r;
    int k;
    logic [CNT_W-1:0]  limit;
    logic [SIZE_W-1:0] sz;
    r = $urandom_range(5);
    unique case (r)
      0: sz = SIZE_W'($urandom_range(7));
      1: sz = 13'd8;
      2: sz = 13'd4096;
      3: sz = 13'd8191;
      default: sz = SIZE_W'($urandom_range(8191));
    endcase
    write_reg(fbfl_pkg::REG_BLOCK_SIZE, CFG_W'(sz));
    write_reg(fbfl_pkg::REG_BLOCK_COUNT, CFG_W'(count_val));
    limit = (int'(count_val) > POOL_DEPTH_DEF) ? CNT_W'(POOL_DEPTH_DEF) : count_val;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n_items) begin
      r = $urandom_range(99);
      if (r < 48) begin
        send_request(fbfl_pkg::OP_ALLOC, 1'($urandom_range(1)),
                     IDX_W'($urandom_range(1023)));
      end else if (r < 78 && held_blocks.size() != 0) begin
        k = $urandom_range(held_blocks.size() - 1);
        send_request(fbfl_pkg::OP_FREE, 1'b1, held_blocks[k]);
        held_blocks.delete(k);
      end else if (r < 84) begin
        send_request(fbfl_pkg::OP_FREE, 1'b0, IDX_W'($urandom_range(1023)));
      end else if (r < 92 && limit != 0) begin
        // Any block in the pool: double frees and overflow come from here.
        send_request(fbfl_pkg::OP_FREE, 1'b1, IDX_W'($urandom_range(int'(limit) - 1)));
      end else begin
        send_request(fbfl_pkg::OP_FREE, 1'b1, IDX_W'($urandom_range(1023)));
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_random_traffic();
    run_traffic(150, 11'd8,    0,  0);
    run_traffic(150, 11'd1024, 57, 0);
    run_traffic(150, 11'd3,    0,  57);
    run_traffic(150, 11'd16,   17, 17);
    run_traffic(150, 11'd2047, 17, 17);
  endtask

  // Hold the receiver off while requests keep coming, so the input stalls.
  task automatic test_backpressure();
    write_reg(fbfl_pkg::REG_BLOCK_COUNT, 13'd4);
    write_reg(fbfl_pkg::REG_BLOCK_SIZE, 13'd64);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> hold_start_ev;
    repeat (40) begin
      if ($urandom_range(1) == 0)
        send_request(fbfl_pkg::OP_ALLOC, 1'($urandom_range(1)),
                     IDX_W'($urandom_range(1023)));
      else
        send_request(fbfl_pkg::OP_FREE, 1'($urandom_range(1)),
                     IDX_W'($urandom_range(7)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    size_reg  = fbfl_pkg::BLOCK_SIZE_RST;
    count_reg = fbfl_pkg::BLOCK_COUNT_RST;
    rebuild_pool();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_pool_edges();
    test_random_traffic();
    test_backpressure();

    // Drain what is still in flight, then give stray results time to show.
    stop_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
